### src/mlk_pkg.sv
`timescale 1ns / 1ps

package mlk_pkg;

   localparam int TickW = 24;
   localparam int CsrW  = 24;
   localparam int AddrW = 2;

   localparam logic [AddrW-1:0] CsrDashOn  = 2'd0;
   localparam logic [AddrW-1:0] CsrDashOff = 2'd1;
   localparam logic [AddrW-1:0] CsrDot     = 2'd2;
   localparam logic [AddrW-1:0] CsrPause   = 2'd3;

   localparam logic [TickW-1:0] DashOnReset  = TickW'(500000);
   localparam logic [TickW-1:0] DashOffReset = TickW'(100000);
   localparam logic [TickW-1:0] DotReset     = TickW'(100000);
   localparam logic [TickW-1:0] PauseReset   = TickW'(600000);

   localparam logic [7:0] CharA = 8'h41;
   localparam logic [7:0] CharZ = 8'h5A;

   // Symbol count in bits 6..4, symbols in bits 3..0 (bit 0 keyed first, 1 = dash).
   localparam logic [6:0] LetterCode [26] = '{
      7'h22, 7'h41, 7'h45, 7'h31, 7'h10, 7'h44, 7'h33, 7'h40, 7'h20, 7'h4E,
      7'h35, 7'h42, 7'h23, 7'h21, 7'h37, 7'h46, 7'h4B, 7'h32, 7'h30, 7'h11,
      7'h34, 7'h48, 7'h36, 7'h49, 7'h4D, 7'h43
   };

   typedef enum logic [1:0] {
      PhIdle,
      PhOn,
      PhOff,
      PhGap
   } phase_type;

   typedef struct packed {
      phase_type        phase;
      logic [TickW-1:0] ticks;
      logic [3:0]       bits;
      logic [2:0]       left;
      logic             led;
   } keyer_state_type;

   typedef struct packed {
      logic [TickW-1:0] dash_on;
      logic [TickW-1:0] dash_off;
      logic [TickW-1:0] dot;
      logic [TickW-1:0] pause;
   } keyer_cfg_type;

   // Packed so that led_on lands in bit 0.
   typedef struct packed {
      logic accepted;
      logic busy_res;
      logic led_on;
   } keyer_rsp_type;

   function automatic keyer_state_type mlk_drop(input keyer_state_type s);
      keyer_state_type r;
      r      = s;
      r.bits = {1'b0, s.bits[3:1]};
      r.left = s.left - 3'd1;
      return r;
   endfunction

   // Walks to the first nonzero symbol phase, or to the gap (idle if pause is 0).
   function automatic keyer_state_type mlk_next_symbol(input keyer_state_type s,
                                                       input keyer_cfg_type c);
      keyer_state_type  r;
      logic             done;
      logic [TickW-1:0] on_len;
      logic [TickW-1:0] off_len;
      r    = s;
      done = 1'b0;
      for (int i = 0; i < 4; i++) begin
         on_len  = r.bits[0] ? c.dash_on : c.dot;
         off_len = r.bits[0] ? c.dash_off : c.dot;
         if (!done && r.left != 3'd0) begin
            if (on_len != '0) begin
               r.ticks = on_len;
               r.led   = 1'b1;
               r.phase = PhOn;
               done    = 1'b1;
            end else if (off_len != '0) begin
               r.ticks = off_len;
               r.led   = 1'b0;
               r.phase = PhOff;
               done    = 1'b1;
            end else begin
               r     = mlk_drop(r);
               r.led = 1'b0;
            end
         end
      end
      if (!done) begin
         r.led   = 1'b0;
         r.ticks = c.pause;
         r.phase = (c.pause == '0) ? PhIdle : PhGap;
      end
      return r;
   endfunction

   // End of a lit phase: go dark for the symbol, or skip on if that is empty.
   function automatic keyer_state_type mlk_after_on(input keyer_state_type s,
                                                    input keyer_cfg_type c);
      keyer_state_type  r;
      logic [TickW-1:0] off_len;
      r       = s;
      off_len = s.bits[0] ? c.dash_off : c.dot;
      r.led   = 1'b0;
      if (off_len != '0) begin
         r.ticks = off_len;
         r.phase = PhOff;
      end else begin
         r = mlk_next_symbol(mlk_drop(r), c);
      end
      return r;
   endfunction

endpackage

### src/mlk_keyer.sv
`timescale 1ns / 1ps

module mlk_keyer
   import mlk_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          beat,
   input  logic          op,
   input  logic [7:0]    character,
   input  keyer_cfg_type cfg,
   output keyer_rsp_type rsp
);

   keyer_state_type state_ff;
   keyer_state_type state_in;
   keyer_state_type loaded;
   keyer_state_type counted;
   logic [4:0]      letter_idx;
   logic [6:0]      code;
   logic            is_letter;
   logic            acc;

   assign is_letter  = (character >= CharA) && (character <= CharZ);
   assign letter_idx = 5'(character - CharA);
   assign code       = is_letter ? LetterCode[letter_idx] : 7'd0;

   always_comb begin
      state_in = state_ff;
      acc      = 1'b0;
      loaded   = state_ff;
      counted  = state_ff;
      loaded.bits = code[3:0];
      loaded.left = code[6:4];
      if (counted.ticks != '0) begin
         counted.ticks = counted.ticks - TickW'(1);
      end
      if (beat) begin
         if (!op) begin
            if (state_ff.phase == PhIdle) begin
               acc      = 1'b1;
               state_in = mlk_next_symbol(loaded, cfg);
            end
         end else if (state_ff.phase != PhIdle) begin
            if (counted.ticks == '0) begin
               case (counted.phase)
                  PhOn:    state_in = mlk_after_on(counted, cfg);
                  PhOff:   state_in = mlk_next_symbol(mlk_drop(counted), cfg);
                  default: begin
                     state_in       = counted;
                     state_in.phase = PhIdle;
                     state_in.led   = 1'b0;
                  end
               endcase
            end else begin
               state_in = counted;
            end
         end
      end
   end

   assign rsp.led_on   = state_in.led;
   assign rsp.busy_res = (state_in.phase != PhIdle);
   assign rsp.accepted = acc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PhIdle, ticks: '0, bits: '0, left: '0, led: 1'b0};
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### src/morse_led_keyer.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tuser: op; tdata: character
// rsp      out        rsp_tvalid/tready     tdata: led_on, busy_res, accepted
// csr      in         csr_we (no wait)      csr_addr selects, csr_wdata value
//
// One beat is taken per cycle while req_tready is high; its result is registered
// and shows in the next cycle. The keyer state updates in the same cycle as the
// accepting edge, so beats may follow each other with no bubble. req_tready drops
// only while a result waits and rsp_tready is low. Synchronous reset restores the
// default timings and leaves the keyer idle with the LED off.

module morse_led_keyer
   import mlk_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] character
   input  logic             req_tuser,   // [0] op: 0 = character, 1 = tick
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [0] led_on, [1] busy_res, [2] accepted
   input  logic             csr_we,
   input  logic [AddrW-1:0] csr_addr,
   input  logic [CsrW-1:0]  csr_wdata
);

   keyer_cfg_type cfg_ff;
   keyer_rsp_type rsp_data_ff;
   keyer_rsp_type rsp_next;
   logic          rsp_valid_ff;
   logic          beat;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign beat       = req_tvalid && req_tready;

   mlk_keyer u_keyer (
      .clock     (clock),
      .reset     (reset),
      .beat      (beat),
      .op        (req_tuser),
      .character (req_tdata),
      .cfg       (cfg_ff),
      .rsp       (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{dash_on: DashOnReset, dash_off: DashOffReset,
                     dot: DotReset, pause: PauseReset};
      end else if (csr_we) begin
         case (csr_addr)
            CsrDashOn:  cfg_ff.dash_on  <= csr_wdata;
            CsrDashOff: cfg_ff.dash_off <= csr_wdata;
            CsrDot:     cfg_ff.dot      <= csr_wdata;
            CsrPause:   cfg_ff.pause    <= csr_wdata;
            default:    cfg_ff          <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (beat) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (beat) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};

endmodule

### src/mlk_check.sv
`timescale 1ns / 1ps

module mlk_check (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       req_tuser,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // Nothing is left over from before a reset.
   a_reset_clears: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // Every request beat gives a result on the next cycle, and a tick never takes a character.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid && !(rsp_tdata[2] && $past(req_tuser)))
      else $error("request beat without matching result");

   // A lit LED only happens in the middle of keying.
   a_lit_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[1])
      else $error("LED lit while keyer idle");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

endmodule

bind morse_led_keyer mlk_check u_mlk_check (.*);
